// ===== rtl/wlsqg_pkg.sv =====
// Shared types, constants and saturation helpers for the weighted
// least-squares cell gradient block. No dependencies.
`timescale 1ns / 1ps
package wlsqg_pkg;

  localparam int DATA_W    = 32;
  localparam int FRAC_W    = 16;
  localparam int NUM_VARS  = 4;
  localparam int VAR_W     = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
  localparam int NUM_TERMS = 3 + 2 * NUM_VARS;
  localparam int TERM_W    = $clog2(NUM_TERMS);
  localparam int MUL_W     = 34;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int SUM_W     = 64;
  localparam int NUM_W     = 128;
  localparam int THR_W     = 32;

  localparam logic [1:0] MUL_TERM  = 2'd0;
  localparam logic [1:0] MUL_DET_A = 2'd1;
  localparam logic [1:0] MUL_DET_B = 2'd2;
  localparam logic [1:0] MUL_SOLVE = 2'd3;

  typedef struct packed {
    logic              load_in;
    logic [1:0]        mul_op;
    logic [TERM_W-1:0] term;
    logic              d2_ld;
    logic              d2_add;
    logic              tdiv_go;
    logic              tacc;
    logic              clamp;
    logic              det_ld;
    logic              det_sub;
    logic              dcmp;
    logic [VAR_W-1:0]  var_k;
    logic              axis;
    logic [1:0]        phase;
    logic              sacc;
    logic              sdiv_go;
    logic              sstore;
    logic              out_load;
    logic              clr_sums;
  } wlsqg_cmd_t;

  typedef struct packed {
    logic d2_zero;
    logic last;
    logic degen;
    logic div_done;
  } wlsqg_stat_t;

  function automatic logic signed [SUM_W-1:0] sat_add64(input logic signed [SUM_W-1:0] a,
                                                        input logic signed [SUM_W-1:0] b);
    logic signed [SUM_W:0]   s;
    logic signed [SUM_W-1:0] r;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      r = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      r = s[SUM_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_mag(input logic [SUM_W-1:0] mag,
                                                      input logic neg);
    logic [SUM_W-1:0] m;
    m = mag[SUM_W-1] ? {1'b0, {(SUM_W-1){1'b1}}} : mag;
    return neg ? $signed(~m + 1'b1) : $signed(m);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [SUM_W-1:0] a);
    logic signed [31:0] r;
    if ((&a[SUM_W-1:31]) || !(|a[SUM_W-1:31])) begin
      r = a[31:0];
    end else begin
      r = a[SUM_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

// ===== rtl/weighted_lsq_cell_gradient.sv =====
// Weighted least-squares gradient of one 2-D cell from a run of neighbor
// requests. Instantiates wlsqg_ctrl and wlsqg_dp; uses wlsqg_pkg.
//
// Each neighbor request with nonzero distance computes eleven weighted
// terms, each a product and a 64-step division on the one shared
// bit-serial divider. A zero-distance neighbor skips the terms. The last
// neighbor adds the solve (eight divisions), which is skipped when the
// stencil is degenerate. The result sits in an output register, so a new
// request is taken while it waits to be read.
`timescale 1ns / 1ps
module weighted_lsq_cell_gradient (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_offset_x,
  input  logic signed [31:0] in_offset_y,
  input  logic signed [31:0] in_neighbor_q0,
  input  logic signed [31:0] in_neighbor_q1,
  input  logic signed [31:0] in_neighbor_q2,
  input  logic signed [31:0] in_neighbor_q3,
  input  logic signed [31:0] in_center_q0,
  input  logic signed [31:0] in_center_q1,
  input  logic signed [31:0] in_center_q2,
  input  logic signed [31:0] in_center_q3,
  input  logic               in_last_neighbor,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_grad_x_q0,
  output logic signed [31:0] out_grad_x_q1,
  output logic signed [31:0] out_grad_x_q2,
  output logic signed [31:0] out_grad_x_q3,
  output logic signed [31:0] out_grad_y_q0,
  output logic signed [31:0] out_grad_y_q1,
  output logic signed [31:0] out_grad_y_q2,
  output logic signed [31:0] out_grad_y_q3,
  output logic               out_degenerate
);
  import wlsqg_pkg::*;

  wlsqg_cmd_t  cmd;
  wlsqg_stat_t stat;

  assign cfg_ready = 1'b1;

  wlsqg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wlsqg_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_valid),
    .cfg_data      (cfg_data),
    .offset_x      (in_offset_x),
    .offset_y      (in_offset_y),
    .neighbor_q0   (in_neighbor_q0),
    .neighbor_q1   (in_neighbor_q1),
    .neighbor_q2   (in_neighbor_q2),
    .neighbor_q3   (in_neighbor_q3),
    .center_q0     (in_center_q0),
    .center_q1     (in_center_q1),
    .center_q2     (in_center_q2),
    .center_q3     (in_center_q3),
    .last_neighbor (in_last_neighbor),
    .grad_x_q0     (out_grad_x_q0),
    .grad_x_q1     (out_grad_x_q1),
    .grad_x_q2     (out_grad_x_q2),
    .grad_x_q3     (out_grad_x_q3),
    .grad_y_q0     (out_grad_y_q0),
    .grad_y_q1     (out_grad_y_q1),
    .grad_y_q2     (out_grad_y_q2),
    .grad_y_q3     (out_grad_y_q3),
    .degenerate    (out_degenerate)
  );

endmodule

// ===== rtl/wlsqg_div.sv =====
// Restoring 128/64 unsigned divider, one quotient bit per cycle,
// quotient saturated when it would not fit 64 bits. Uses wlsqg_pkg.
`timescale 1ns / 1ps
module wlsqg_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dvd_hi,
  input  logic [63:0] dvd_lo,
  input  logic [63:0] dvs,
  output logic        done,
  output logic [63:0] quo
);
  import wlsqg_pkg::*;

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] rem_r, lo_r, dvs_r, quo_r;
  logic [64:0] trial;
  logic        ge;
  logic [63:0] rem_nxt;
  logic        sat;

  assign sat     = (dvs == 64'd0) || (dvd_hi >= dvs);
  assign trial   = {rem_r, lo_r[63]};
  assign ge      = trial >= {1'b0, dvs_r};
  assign rem_nxt = ge ? 64'(trial - {1'b0, dvs_r}) : trial[63:0];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    if (start) begin
      busy_nxt = !sat;
      done_nxt = sat;
      cnt_nxt  = 6'd63;
    end else if (busy_r) begin
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dvd_hi;
      lo_r  <= dvd_lo;
      dvs_r <= dvs;
      quo_r <= sat ? {64{1'b1}} : 64'd0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      lo_r  <= {lo_r[62:0], 1'b0};
      quo_r <= {quo_r[62:0], ge};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// ===== rtl/wlsqg_dp.sv =====
// Datapath: input capture, shared multiplier, accumulators, solve registers,
// output register. Uses wlsqg_pkg and wlsqg_div.
`timescale 1ns / 1ps
module wlsqg_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wlsqg_pkg::wlsqg_cmd_t       cmd,
  output wlsqg_pkg::wlsqg_stat_t      stat,
  input  logic                        cfg_we,
  input  logic [31:0]                 cfg_data,
  input  logic signed [31:0]          offset_x,
  input  logic signed [31:0]          offset_y,
  input  logic signed [31:0]          neighbor_q0,
  input  logic signed [31:0]          neighbor_q1,
  input  logic signed [31:0]          neighbor_q2,
  input  logic signed [31:0]          neighbor_q3,
  input  logic signed [31:0]          center_q0,
  input  logic signed [31:0]          center_q1,
  input  logic signed [31:0]          center_q2,
  input  logic signed [31:0]          center_q3,
  input  logic                        last_neighbor,
  output logic signed [31:0]          grad_x_q0,
  output logic signed [31:0]          grad_x_q1,
  output logic signed [31:0]          grad_x_q2,
  output logic signed [31:0]          grad_x_q3,
  output logic signed [31:0]          grad_y_q0,
  output logic signed [31:0]          grad_y_q1,
  output logic signed [31:0]          grad_y_q2,
  output logic signed [31:0]          grad_y_q3,
  output logic                        degenerate
);
  import wlsqg_pkg::*;

  logic [THR_W-1:0]         thr_r;
  logic [DATA_W-1:0]        ax_r, ay_r;
  logic                     sx_r, sy_r, last_r;
  logic signed [DATA_W:0]   dq_r [NUM_VARS];
  logic [DATA_W:0]          aq   [NUM_VARS];
  logic signed [DATA_W:0]   nq   [NUM_VARS];
  logic signed [DATA_W:0]   cq   [NUM_VARS];
  logic signed [PROD_W-1:0] prod_r;
  logic [SUM_W-1:0]         d2_r;
  logic signed [SUM_W-1:0]  wxx_r, wxy_r, wyy_r;
  logic signed [SUM_W-1:0]  rx_r [NUM_VARS];
  logic signed [SUM_W-1:0]  ry_r [NUM_VARS];
  logic signed [31:0]       a11_r, a12_r, a22_r;
  logic signed [SUM_W-1:0]  det_r;
  logic                     degen_r;
  logic signed [NUM_W-1:0]  num_r;
  logic                     neg_r;
  logic signed [31:0]       gx_r [NUM_VARS];
  logic signed [31:0]       gy_r [NUM_VARS];
  logic signed [31:0]       ox_r [NUM_VARS];
  logic signed [31:0]       oy_r [NUM_VARS];
  logic                     odeg_r;

  logic [TERM_W-1:0]        qidx;
  logic [VAR_W-1:0]         qk;
  logic                     qaxis;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [31:0]       coef;
  logic signed [SUM_W-1:0]  rsrc;
  logic                     term_neg;
  logic [NUM_W-1:0]         tsh, nmag, nsh;
  logic [SUM_W-1:0]         absdet, thr64;
  logic                     div_go, div_done;
  logic [63:0]              div_hi, div_lo, div_dvs, quo;
  logic signed [SUM_W-1:0]  qval;
  logic signed [NUM_W-1:0]  pe, ps, pv;
  logic [63:0]              lim, qs;
  logic signed [31:0]       gval;

  assign nq[0] = {neighbor_q0[31], neighbor_q0};
  assign nq[1] = {neighbor_q1[31], neighbor_q1};
  assign nq[2] = {neighbor_q2[31], neighbor_q2};
  assign nq[3] = {neighbor_q3[31], neighbor_q3};
  assign cq[0] = {center_q0[31], center_q0};
  assign cq[1] = {center_q1[31], center_q1};
  assign cq[2] = {center_q2[31], center_q2};
  assign cq[3] = {center_q3[31], center_q3};

  always_comb begin
    for (int k = 0; k < NUM_VARS; k++) begin
      aq[k] = dq_r[k][DATA_W] ? (DATA_W+1)'(~dq_r[k] + 1'b1) : dq_r[k];
    end
  end

  assign qidx  = cmd.term - TERM_W'(3);
  assign qk    = qidx[VAR_W:1];
  assign qaxis = qidx[0];

  always_comb begin
    coef = (cmd.phase[1] == 1'b0) ? (cmd.axis ? a11_r : a22_r) : a12_r;
    if (cmd.phase[1] == 1'b0) begin
      rsrc = cmd.axis ? ry_r[cmd.var_k] : rx_r[cmd.var_k];
    end else begin
      rsrc = cmd.axis ? rx_r[cmd.var_k] : ry_r[cmd.var_k];
    end
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      MUL_TERM: begin
        case (cmd.term)
          TERM_W'(0): begin
            mul_a = {2'b00, ax_r};
            mul_b = {2'b00, ax_r};
          end
          TERM_W'(1): begin
            mul_a = {2'b00, ay_r};
            mul_b = {2'b00, ay_r};
          end
          TERM_W'(2): begin
            mul_a = {2'b00, ax_r};
            mul_b = {2'b00, ay_r};
          end
          default: begin
            mul_a = {1'b0, aq[qk]};
            mul_b = {2'b00, qaxis ? ay_r : ax_r};
          end
        endcase
      end
      MUL_DET_A: begin
        mul_a = {{2{a11_r[31]}}, a11_r};
        mul_b = {{2{a22_r[31]}}, a22_r};
      end
      MUL_DET_B: begin
        mul_a = {{2{a12_r[31]}}, a12_r};
        mul_b = {{2{a12_r[31]}}, a12_r};
      end
      MUL_SOLVE: begin
        mul_a = {{2{coef[31]}}, coef};
        mul_b = cmd.phase[0] ? {{2{rsrc[63]}}, rsrc[63:32]} : {2'b00, rsrc[31:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd.term)
      TERM_W'(0): term_neg = 1'b0;
      TERM_W'(1): term_neg = 1'b0;
      TERM_W'(2): term_neg = sx_r ^ sy_r;
      default:    term_neg = dq_r[qk][DATA_W] ^ (qaxis ? sy_r : sx_r);
    endcase
  end

  assign tsh    = NUM_W'(prod_r[SUM_W-1:0]) << FRAC_W;
  assign nmag   = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);
  assign nsh    = nmag << FRAC_W;
  assign absdet = det_r[SUM_W-1] ? SUM_W'(-det_r) : SUM_W'(det_r);
  assign thr64  = SUM_W'(thr_r) << FRAC_W;

  assign div_go  = cmd.tdiv_go | cmd.sdiv_go;
  assign div_hi  = cmd.sdiv_go ? nsh[127:64] : tsh[127:64];
  assign div_lo  = cmd.sdiv_go ? nsh[63:0] : tsh[63:0];
  assign div_dvs = cmd.sdiv_go ? absdet : d2_r;

  wlsqg_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_go),
    .dvd_hi (div_hi),
    .dvd_lo (div_lo),
    .dvs    (div_dvs),
    .done   (div_done),
    .quo    (quo)
  );

  assign qval = sat_mag(quo, neg_r);

  assign pe = {{(NUM_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
  assign ps = cmd.phase[0] ? (pe <<< 32) : pe;
  assign pv = cmd.phase[1] ? -ps : ps;

  assign lim = 64'd1 << (DATA_W - 1);
  always_comb begin
    if (neg_r) begin
      qs   = (quo > lim) ? lim : quo;
      gval = 32'(~qs + 1'b1);
    end else begin
      qs   = (quo > lim - 64'd1) ? lim - 64'd1 : quo;
      gval = qs[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_W'(1);
    end else if (cfg_we) begin
      thr_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wxx_r <= '0;
      wxy_r <= '0;
      wyy_r <= '0;
      for (int k = 0; k < NUM_VARS; k++) begin
        rx_r[k] <= '0;
        ry_r[k] <= '0;
      end
    end else if (cmd.clr_sums) begin
      wxx_r <= '0;
      wxy_r <= '0;
      wyy_r <= '0;
      for (int k = 0; k < NUM_VARS; k++) begin
        rx_r[k] <= '0;
        ry_r[k] <= '0;
      end
    end else if (cmd.tacc) begin
      case (cmd.term)
        TERM_W'(0): wxx_r <= sat_add64(wxx_r, qval);
        TERM_W'(1): wyy_r <= sat_add64(wyy_r, qval);
        TERM_W'(2): wxy_r <= sat_add64(wxy_r, qval);
        default: begin
          if (qaxis) begin
            ry_r[qk] <= sat_add64(ry_r[qk], qval);
          end else begin
            rx_r[qk] <= sat_add64(rx_r[qk], qval);
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (cmd.load_in) begin
      ax_r   <= offset_x[31] ? 32'(~offset_x + 1'b1) : offset_x;
      ay_r   <= offset_y[31] ? 32'(~offset_y + 1'b1) : offset_y;
      sx_r   <= offset_x[31];
      sy_r   <= offset_y[31];
      last_r <= last_neighbor;
      for (int k = 0; k < NUM_VARS; k++) begin
        dq_r[k] <= nq[k] - cq[k];
      end
    end
    if (cmd.d2_ld) begin
      d2_r <= prod_r[SUM_W-1:0];
    end else if (cmd.d2_add) begin
      d2_r <= d2_r + prod_r[SUM_W-1:0];
    end
    if (cmd.tdiv_go) begin
      neg_r <= term_neg;
    end else if (cmd.sdiv_go) begin
      neg_r <= num_r[NUM_W-1] ^ det_r[SUM_W-1];
    end
    if (cmd.clamp) begin
      a11_r <= clamp32(wxx_r);
      a12_r <= clamp32(wxy_r);
      a22_r <= clamp32(wyy_r);
    end
    if (cmd.det_ld) begin
      det_r <= prod_r[SUM_W-1:0];
    end else if (cmd.det_sub) begin
      det_r <= det_r - prod_r[SUM_W-1:0];
    end
    if (cmd.dcmp) begin
      degen_r <= absdet <= thr64;
    end
    if (cmd.sacc) begin
      num_r <= (cmd.phase == 2'd0) ? pv : num_r + pv;
    end
    if (cmd.sstore) begin
      if (cmd.axis) begin
        gy_r[cmd.var_k] <= gval;
      end else begin
        gx_r[cmd.var_k] <= gval;
      end
    end
    if (cmd.out_load) begin
      odeg_r <= degen_r;
      for (int k = 0; k < NUM_VARS; k++) begin
        ox_r[k] <= degen_r ? 32'sd0 : gx_r[k];
        oy_r[k] <= degen_r ? 32'sd0 : gy_r[k];
      end
    end
  end

  assign stat.d2_zero  = (d2_r == '0);
  assign stat.last     = last_r;
  assign stat.degen    = absdet <= thr64;
  assign stat.div_done = div_done;

  assign grad_x_q0  = ox_r[0];
  assign grad_x_q1  = ox_r[1];
  assign grad_x_q2  = ox_r[2];
  assign grad_x_q3  = ox_r[3];
  assign grad_y_q0  = oy_r[0];
  assign grad_y_q1  = oy_r[1];
  assign grad_y_q2  = oy_r[2];
  assign grad_y_q3  = oy_r[3];
  assign degenerate = odeg_r;

endmodule

// ===== rtl/wlsqg_ctrl.sv =====
// Controller: sequences accumulation per neighbor and the Cramer solve,
// owns the request handshakes. Uses wlsqg_pkg.
`timescale 1ns / 1ps
module wlsqg_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  wlsqg_pkg::wlsqg_stat_t stat,
  output wlsqg_pkg::wlsqg_cmd_t  cmd
);
  import wlsqg_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DXX   = 5'd1;
  localparam logic [4:0] S_DYY   = 5'd2;
  localparam logic [4:0] S_DSUM  = 5'd3;
  localparam logic [4:0] S_DCHK  = 5'd4;
  localparam logic [4:0] S_TMUL  = 5'd5;
  localparam logic [4:0] S_TDIV  = 5'd6;
  localparam logic [4:0] S_TWAIT = 5'd7;
  localparam logic [4:0] S_TACC  = 5'd8;
  localparam logic [4:0] S_CLAMP = 5'd9;
  localparam logic [4:0] S_DET1  = 5'd10;
  localparam logic [4:0] S_DET2  = 5'd11;
  localparam logic [4:0] S_DET3  = 5'd12;
  localparam logic [4:0] S_DCMP  = 5'd13;
  localparam logic [4:0] S_SMUL  = 5'd14;
  localparam logic [4:0] S_SACC  = 5'd15;
  localparam logic [4:0] S_SDIV  = 5'd16;
  localparam logic [4:0] S_SWAIT = 5'd17;
  localparam logic [4:0] S_SSTOR = 5'd18;
  localparam logic [4:0] S_PUSH  = 5'd19;

  logic [4:0]        state_r, state_nxt;
  logic [TERM_W-1:0] term_r, term_nxt;
  logic [VAR_W-1:0]  k_r, k_nxt;
  logic              axis_r, axis_nxt;
  logic [1:0]        phase_r, phase_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic              push_ok;

  assign push_ok = !ovalid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    k_nxt     = k_r;
    axis_nxt  = axis_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.mul_op = MUL_TERM;
    cmd.term   = term_r;
    cmd.var_k  = k_r;
    cmd.axis   = axis_r;
    cmd.phase  = phase_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DXX;
        end
      end
      S_DXX: begin
        cmd.term  = TERM_W'(0);
        state_nxt = S_DYY;
      end
      S_DYY: begin
        cmd.term  = TERM_W'(1);
        cmd.d2_ld = 1'b1;
        state_nxt = S_DSUM;
      end
      S_DSUM: begin
        cmd.d2_add = 1'b1;
        state_nxt  = S_DCHK;
      end
      S_DCHK: begin
        term_nxt = '0;
        if (!stat.d2_zero) begin
          state_nxt = S_TMUL;
        end else if (stat.last) begin
          state_nxt = S_CLAMP;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_TMUL: begin
        state_nxt = S_TDIV;
      end
      S_TDIV: begin
        cmd.tdiv_go = 1'b1;
        state_nxt   = S_TWAIT;
      end
      S_TWAIT: begin
        if (stat.div_done) begin
          state_nxt = S_TACC;
        end
      end
      S_TACC: begin
        cmd.tacc = 1'b1;
        if (term_r == TERM_W'(NUM_TERMS - 1)) begin
          state_nxt = stat.last ? S_CLAMP : S_IDLE;
        end else begin
          term_nxt  = term_r + 1'b1;
          state_nxt = S_TMUL;
        end
      end
      S_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = S_DET1;
      end
      S_DET1: begin
        cmd.mul_op = MUL_DET_A;
        state_nxt  = S_DET2;
      end
      S_DET2: begin
        cmd.mul_op = MUL_DET_B;
        cmd.det_ld = 1'b1;
        state_nxt  = S_DET3;
      end
      S_DET3: begin
        cmd.det_sub = 1'b1;
        state_nxt   = S_DCMP;
      end
      S_DCMP: begin
        cmd.dcmp  = 1'b1;
        k_nxt     = '0;
        axis_nxt  = 1'b0;
        phase_nxt = 2'd0;
        state_nxt = stat.degen ? S_PUSH : S_SMUL;
      end
      S_SMUL: begin
        cmd.mul_op = MUL_SOLVE;
        state_nxt  = S_SACC;
      end
      S_SACC: begin
        cmd.sacc = 1'b1;
        if (phase_r == 2'd3) begin
          state_nxt = S_SDIV;
        end else begin
          phase_nxt = phase_r + 2'd1;
          state_nxt = S_SMUL;
        end
      end
      S_SDIV: begin
        cmd.sdiv_go = 1'b1;
        state_nxt   = S_SWAIT;
      end
      S_SWAIT: begin
        if (stat.div_done) begin
          state_nxt = S_SSTOR;
        end
      end
      S_SSTOR: begin
        cmd.sstore = 1'b1;
        phase_nxt  = 2'd0;
        if (axis_r && k_r == VAR_W'(NUM_VARS - 1)) begin
          state_nxt = S_PUSH;
        end else begin
          if (axis_r) begin
            k_nxt = k_r + 1'b1;
          end
          axis_nxt  = !axis_r;
          state_nxt = S_SMUL;
        end
      end
      S_PUSH: begin
        if (push_ok) begin
          cmd.out_load = 1'b1;
          cmd.clr_sums = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      ovalid_nxt = 1'b1;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end else begin
      ovalid_nxt = ovalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      term_r   <= '0;
      k_r      <= '0;
      axis_r   <= 1'b0;
      phase_r  <= 2'd0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      term_r   <= term_nxt;
      k_r      <= k_nxt;
      axis_r   <= axis_nxt;
      phase_r  <= phase_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ovalid_r;

endmodule
